FILE: src/ihq_pkg.sv
// Shared types and constants of the indexed max-heap vote queue.
package ihq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BITS_DEF = 16;

    localparam int REQ_W    = 2;
    localparam int ID_W     = 4;
    localparam int KEYIN_W  = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT   = 2'd0,
        REQ_UPVOTE   = 2'd1,
        REQ_DOWNVOTE = 2'd2,
        REQ_DELETE   = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        t_req req;
        logic latch_req;
        logic start_insert;
        logic set_full;
        logic set_absent;
        logic load_hole;
        logic load_entry;
        logic rd_parent;
        logic move_parent;
        logic rd_left;
        logic take_left;
        logic rd_right;
        logic decide_l;
        logic decide_lr;
        logic place;
        logic out_load;
    } t_cmd;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic fresh_full;
        logic id_bad;
        logic key_zero;
        logic hole_last;
        logic hole_root;
        logic parent_smaller;
        logic left_in;
        logic right_in;
        logic dn_move_l;
        logic dn_move_lr;
        logic out_free;
    } t_stat;

endpackage

FILE: src/ihq_ctrl.sv
// Request sequencer of the indexed max-heap vote queue.
module ihq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    input  ihq_pkg::t_req  i_req,
    input  ihq_pkg::t_stat i_stat,
    output logic           o_s_ready,
    output ihq_pkg::t_cmd  o_cmd
);
    import ihq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POS,
        S_LOAD,
        S_UP,
        S_UP_CMP,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_PLACE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_req   r_req;
    t_req   n_req;

    assign o_s_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd     = '0;
        o_cmd.req = (r_state == S_IDLE) ? i_req : r_req;
        n_state   = r_state;
        n_req     = r_req;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.latch_req = 1'b1;
                    n_req           = i_req;
                    if (i_req == REQ_INSERT) begin
                        if (i_stat.fresh_full) begin
                            o_cmd.set_full = 1'b1;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.start_insert = 1'b1;
                            n_state            = S_UP;
                        end
                    end else if (i_stat.id_bad) begin
                        o_cmd.set_absent = 1'b1;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_POS;
                    end
                end
            end
            S_POS: begin
                o_cmd.load_hole = 1'b1;
                n_state         = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_entry = 1'b1;
                case (r_req)
                    REQ_UPVOTE:   n_state = S_UP;
                    REQ_DOWNVOTE: n_state = i_stat.key_zero ? S_DONE : S_DN;
                    REQ_DELETE:   n_state = i_stat.hole_last ? S_DONE : S_UP;
                    default:      n_state = S_DONE;
                endcase
            end
            S_UP: begin
                if (i_stat.hole_root) begin
                    n_state = (r_req == REQ_DELETE) ? S_DN : S_PLACE;
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.parent_smaller) begin
                    o_cmd.move_parent = 1'b1;
                    n_state           = S_UP;
                end else begin
                    n_state = (r_req == REQ_DELETE) ? S_DN : S_PLACE;
                end
            end
            S_DN: begin
                if (i_stat.left_in) begin
                    o_cmd.rd_left = 1'b1;
                    n_state       = S_DN_L;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DN_L: begin
                o_cmd.take_left = 1'b1;
                if (i_stat.right_in) begin
                    o_cmd.rd_right = 1'b1;
                    n_state        = S_DN_R;
                end else begin
                    o_cmd.decide_l = 1'b1;
                    n_state        = i_stat.dn_move_l ? S_DN : S_PLACE;
                end
            end
            S_DN_R: begin
                o_cmd.decide_lr = 1'b1;
                n_state         = i_stat.dn_move_lr ? S_DN : S_PLACE;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= REQ_INSERT;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
        end
    end

endmodule

FILE: src/ihq_dp.sv
// Heap slot memory, position map, counters and result register.
module ihq_dp #(
    parameter int CAPACITY = ihq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = ihq_pkg::KEY_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ihq_pkg::t_cmd                i_cmd,
    input  logic [ihq_pkg::ID_W-1:0]     i_id,
    input  logic [ihq_pkg::KEYIN_W-1:0]  i_key,
    input  logic                         i_m_ready,
    output ihq_pkg::t_stat               o_stat,
    output logic                         o_m_valid,
    output logic [ihq_pkg::STATUS_W-1:0] o_status,
    output logic [ihq_pkg::ID_W-1:0]     o_assigned,
    output logic [ihq_pkg::ID_W-1:0]     o_top_id,
    output logic [ihq_pkg::KEYIN_W-1:0]  o_top_key,
    output logic [ihq_pkg::COUNT_W-1:0]  o_count
);
    import ihq_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int SIZE_W = $clog2(CAPACITY + 1);
    localparam int IDX_W  = SLOT_W + 2;

    // Slot memory (id and key share an address) and the id-to-slot map.
    logic [SLOT_W-1:0]   r_slot_id_mem  [CAPACITY];
    logic [KEY_BITS-1:0] r_slot_key_mem [CAPACITY];
    logic [SLOT_W-1:0]   r_pos_mem      [CAPACITY];

    logic [CAPACITY-1:0] r_valid;
    logic [SIZE_W-1:0]   r_size;
    logic [SIZE_W-1:0]   r_fresh;
    logic [SLOT_W-1:0]   r_tgt;
    logic [SLOT_W-1:0]   r_hole;
    logic [SLOT_W-1:0]   r_e_id;
    logic [KEY_BITS-1:0] r_e_key;
    logic [SLOT_W-1:0]   r_l_id;
    logic [KEY_BITS-1:0] r_l_key;
    logic [SLOT_W-1:0]   r_rd_id;
    logic [KEY_BITS-1:0] r_rd_key;
    logic [SLOT_W-1:0]   r_pos_rd;
    logic [SLOT_W-1:0]   r_top_id;
    logic [KEY_BITS-1:0] r_top_key;
    t_status             r_status;
    logic [ID_W-1:0]     r_assigned;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [ID_W-1:0]     r_o_assigned;
    logic [ID_W-1:0]     r_o_top_id;
    logic [KEYIN_W-1:0]  r_o_top_key;
    logic [COUNT_W-1:0]  r_o_count;

    logic [SLOT_W-1:0]   in_idx;
    logic [SIZE_W-1:0]   size_m1;
    logic [SLOT_W-1:0]   parent;
    logic [IDX_W-1:0]    left_w;
    logic [IDX_W-1:0]    right_w;
    logic [IDX_W-1:0]    size_w;
    logic                left_wins;
    logic [KEY_BITS-1:0] lr_ref;
    logic                right_wins;

    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                w_en;
    logic [SLOT_W-1:0]   w_addr;
    logic [SLOT_W-1:0]   w_id;
    logic [KEY_BITS-1:0] w_key;
    logic [SLOT_W-1:0]   n_hole;

    assign in_idx  = SLOT_W'(i_id);
    assign size_m1 = r_size - SIZE_W'(1);
    assign parent  = SLOT_W'((r_hole - SLOT_W'(1)) >> 1);
    assign left_w  = {1'b0, r_hole, 1'b1};
    assign right_w = left_w + IDX_W'(1);
    assign size_w  = IDX_W'(r_size);

    // Down-step choice: the larger child, left on a tie, only if strictly larger.
    assign left_wins  = r_l_key > r_e_key;
    assign lr_ref     = left_wins ? r_l_key : r_e_key;
    assign right_wins = r_rd_key > lr_ref;

    always_comb begin
        o_stat                = '0;
        o_stat.fresh_full     = (32'(r_fresh) >= CAPACITY) || (32'(r_size) >= CAPACITY);
        o_stat.id_bad         = (32'(i_id) >= CAPACITY) || !r_valid[in_idx];
        o_stat.key_zero       = (r_rd_key == '0);
        o_stat.hole_last      = (r_hole == SLOT_W'(size_m1));
        o_stat.hole_root      = (r_hole == '0);
        o_stat.parent_smaller = r_rd_key < r_e_key;
        o_stat.left_in        = left_w < size_w;
        o_stat.right_in       = right_w < size_w;
        o_stat.dn_move_l      = r_rd_key > r_e_key;
        o_stat.dn_move_lr     = right_wins || left_wins;
        o_stat.out_free       = !r_out_valid || i_m_ready;
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_hole;
        if (i_cmd.load_hole) begin
            rd_en   = 1'b1;
            rd_addr = (i_cmd.req == REQ_DELETE) ? SLOT_W'(size_m1) : r_pos_rd;
        end else if (i_cmd.rd_parent) begin
            rd_en   = 1'b1;
            rd_addr = parent;
        end else if (i_cmd.rd_left) begin
            rd_en   = 1'b1;
            rd_addr = SLOT_W'(left_w);
        end else if (i_cmd.rd_right) begin
            rd_en   = 1'b1;
            rd_addr = SLOT_W'(right_w);
        end
    end

    always_comb begin
        w_en   = 1'b0;
        w_addr = r_hole;
        w_id   = r_rd_id;
        w_key  = r_rd_key;
        n_hole = r_hole;
        if (i_cmd.move_parent) begin
            w_en   = 1'b1;
            n_hole = parent;
        end else if (i_cmd.decide_l && (r_rd_key > r_e_key)) begin
            w_en   = 1'b1;
            n_hole = SLOT_W'(left_w);
        end else if (i_cmd.decide_lr && right_wins) begin
            w_en   = 1'b1;
            n_hole = SLOT_W'(right_w);
        end else if (i_cmd.decide_lr && left_wins) begin
            w_en   = 1'b1;
            w_id   = r_l_id;
            w_key  = r_l_key;
            n_hole = SLOT_W'(left_w);
        end else if (i_cmd.place) begin
            w_en  = 1'b1;
            w_id  = r_e_id;
            w_key = r_e_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_id  <= r_slot_id_mem[rd_addr];
            r_rd_key <= r_slot_key_mem[rd_addr];
        end
        if (w_en) begin
            r_slot_id_mem[w_addr]  <= w_id;
            r_slot_key_mem[w_addr] <= w_key;
            r_pos_mem[w_id]        <= w_addr;
        end
        if (i_cmd.latch_req) begin
            r_pos_rd <= r_pos_mem[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_size      <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start_insert) begin
                r_valid[SLOT_W'(r_fresh)] <= 1'b1;
                r_size                    <= r_size + SIZE_W'(1);
                r_fresh                   <= r_fresh + SIZE_W'(1);
            end
            if (i_cmd.load_entry && (i_cmd.req == REQ_DELETE)) begin
                r_valid[r_tgt] <= 1'b0;
                r_size         <= size_m1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_tgt <= in_idx;
            if (i_cmd.set_full) begin
                r_status <= ST_FULL;
            end else if (i_cmd.set_absent) begin
                r_status <= ST_ABSENT;
            end else begin
                r_status <= ST_DONE;
            end
            r_assigned <= i_cmd.start_insert ? ID_W'(r_fresh) : '0;
        end
        if (i_cmd.start_insert) begin
            r_e_id     <= SLOT_W'(r_fresh);
            r_e_key    <= KEY_BITS'(i_key);
            r_hole     <= SLOT_W'(r_size);
        end
        if (i_cmd.load_hole) begin
            r_hole <= r_pos_rd;
        end
        if (i_cmd.load_entry) begin
            r_e_id <= r_rd_id;
            case (i_cmd.req)
                REQ_UPVOTE:   r_e_key <= (r_rd_key == '1) ? r_rd_key
                                                          : r_rd_key + KEY_BITS'(1);
                REQ_DOWNVOTE: r_e_key <= r_rd_key - KEY_BITS'(1);
                default:      r_e_key <= r_rd_key;
            endcase
        end
        if (i_cmd.take_left) begin
            r_l_id  <= r_rd_id;
            r_l_key <= r_rd_key;
        end
        if (i_cmd.move_parent || i_cmd.decide_l || i_cmd.decide_lr) begin
            r_hole <= n_hole;
        end
        if (w_en && (w_addr == '0)) begin
            r_top_id  <= w_id;
            r_top_key <= w_key;
        end
        if (i_cmd.out_load) begin
            r_o_status   <= r_status;
            r_o_assigned <= r_assigned;
            r_o_top_id   <= (r_size != '0) ? ID_W'(r_top_id) : '0;
            r_o_top_key  <= (r_size != '0) ? KEYIN_W'(r_top_key) : '0;
            r_o_count    <= COUNT_W'(r_size);
        end
    end

    assign o_m_valid  = r_out_valid;
    assign o_status   = r_o_status;
    assign o_assigned = r_o_assigned;
    assign o_top_id   = r_o_top_id;
    assign o_top_key  = r_o_top_key;
    assign o_count    = r_o_count;

endmodule

FILE: src/indexed_max_heap_vote_queue_core.sv
// Top level of the indexed max-heap vote queue: stream ports, controller and datapath.
//
// This block keeps up to CAPACITY (id, key) entries in a binary max-heap and a map from
// each id to its heap slot, so that any live entry can be found in one lookup. A request
// beat (insert, upvote, downvote or delete) is taken only while the block is idle; it is
// worked through one heap level at a time on a single-ported slot memory, and then one
// result beat reports the status, the id given on insert, the current top entry and the
// live count. Inserts hand out ids in order from zero and never reuse them, so once
// CAPACITY ids have been given out every further insert is refused. Requests naming an
// id that is out of range or not live return status "id not present" and change nothing.
// Timing is set by the slot memory port, which moves one entry per cycle. A refused
// request goes straight to its result. A downvote of a zero key or a delete of the
// entry in the last slot loads its entry and ends with no walk. An insert and an upvote
// make the upward walk, a downvote the downward walk and any other delete both. The
// upward walk compares the entry with each parent in turn and ends at the root or at a
// parent that is not smaller. The downward walk compares the two children of a slot,
// or only the left one when it has no right child, and ends at a slot with no child or
// when no child is larger. The result sits in an output register, so the next request
// is taken as soon as that register is loaded; a result that is not yet taken holds the
// block only at the end of the following request. The id map is cleared by valid bits
// at reset, so there is no clearing pass.
module indexed_max_heap_vote_queue_core #(
    parameter int CAPACITY = ihq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = ihq_pkg::KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [3:0] entry_id, [19:4] key_value, [23:20] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [3:0] assigned_id, [7:4] top_id,
                                       // [23:8] top_key, [28:24] live_count, [31:29] zero
    output logic [1:0]  m_axis_tuser   // [1:0] status
);
    import ihq_pkg::*;

    t_cmd                cmd;
    t_stat               stat;
    t_req                req;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     assigned;
    logic [ID_W-1:0]     top_id;
    logic [KEYIN_W-1:0]  top_key;
    logic [COUNT_W-1:0]  count;

    // The request kind arrives on tuser; the controller decodes it directly.
    assign req = t_req'(s_axis_tuser);

    ihq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_req     (req),
        .i_stat    (stat),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd)
    );

    ihq_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_id       (s_axis_tdata[3:0]),
        .i_key      (s_axis_tdata[19:4]),
        .i_m_ready  (m_axis_tready),
        .o_stat     (stat),
        .o_m_valid  (m_axis_tvalid),
        .o_status   (status),
        .o_assigned (assigned),
        .o_top_id   (top_id),
        .o_top_key  (top_key),
        .o_count    (count)
    );

    // Result beat: status on tuser, the remaining fields packed from the low bit up.
    assign m_axis_tuser = status;
    assign m_axis_tdata = {3'b000, count, top_key, top_id, assigned};

endmodule
